### rtl/core/lphs_pkg.sv
// Shared types and constants for the linear probing hash set insert core.
// No dependencies; imported by every module of the core.
package lphs_pkg;

  localparam int TABLE_SLOTS  = 32768;
  localparam int SLOT_W       = $clog2(TABLE_SLOTS);
  localparam int KEY_W        = 64;
  localparam int SLOT_FIELD_W = 15;
  localparam int STATUS_W     = 2;

  localparam logic [KEY_W-1:0] GOLDEN_MUL = 64'h9E37_79B9_7F4A_7C15;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // Finished word handed from the probe engine to the output stage.
  typedef struct packed {
    logic                    valid;
    status_t                 status;
    logic [SLOT_FIELD_W-1:0] slot;
  } res_t;

  // Widen or cut a table index to the width of the reported slot field.
  function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+SLOT_FIELD_W-1:0] wide;
    wide = {{SLOT_FIELD_W{1'b0}}, idx};
    return wide[SLOT_FIELD_W-1:0];
  endfunction

endpackage

### rtl/core/lphs_hash.sv
// Start slot unit: multiplicative hash of the key, registered.
// Depends on lphs_pkg.
module lphs_hash import lphs_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [KEY_W-1:0]  key,
  output logic [SLOT_W-1:0] start
);

  // Only the low index bits of the product are kept, so only the low index bits
  // of each factor matter; the key factor is taken from key bits SLOT_W+2 down to 3.
  logic [2*SLOT_W-1:0] prod;

  assign prod = key[SLOT_W+2:3] * GOLDEN_MUL[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      start <= prod[SLOT_W-1:0];
    end
  end

endmodule

### rtl/core/lphs_probe.sv
// Probe engine: key memory, clearing pass after reset and the linear probe
// sequencer. Depends on lphs_pkg.
module lphs_probe import lphs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KEY_W-1:0]  key,
  input  logic [SLOT_W-1:0] start,
  output res_t              res,
  input  logic              res_ready
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_ISSUE = 5'b00100,
    S_PROBE = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  localparam logic [SLOT_W-1:0] SLOT_MAX = '1;

  state_t            state, state_next;
  logic [SLOT_W-1:0] clr_idx;
  logic [SLOT_W-1:0] cur_idx;
  logic [SLOT_W-1:0] cnt;
  logic [KEY_W-1:0]  key_r;
  status_t           hold_status;
  logic [SLOT_W-1:0] hold_idx;

  logic [KEY_W-1:0]  mem [TABLE_SLOTS];
  logic [KEY_W-1:0]  rdata;
  logic              mem_re;
  logic [SLOT_W-1:0] raddr;
  logic              mem_we;
  logic [SLOT_W-1:0] waddr;
  logic [KEY_W-1:0]  wdata;

  logic    hit, empty, last_probe, done;
  status_t probe_status;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  assign hit        = (rdata == key_r);
  assign empty      = (rdata == '0);
  assign last_probe = (cnt == SLOT_MAX);
  assign done       = (state == S_PROBE) && (hit || empty || last_probe);
  assign in_ready   = (state == S_IDLE);

  always_comb begin
    if (hit) begin
      probe_status = ST_PRESENT;
    end else if (empty) begin
      probe_status = ST_INSERTED;
    end else begin
      probe_status = ST_FULL;
    end
  end

  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    raddr      = start;
    mem_we     = 1'b0;
    waddr      = cur_idx;
    wdata      = key_r;
    res.valid  = 1'b0;
    res.status = hold_status;
    res.slot   = slot_field(hold_idx);
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_idx;
        wdata  = '0;
        if (clr_idx == SLOT_MAX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        mem_re     = 1'b1;
        raddr      = start;
        state_next = S_PROBE;
      end
      S_PROBE: begin
        res.status = probe_status;
        res.slot   = slot_field(cur_idx);
        if (done) begin
          res.valid = 1'b1;
          mem_we    = !hit && empty;
          state_next = res_ready ? S_IDLE : S_HOLD;
        end else begin
          // read ahead at the next slot, wrapping at the top
          mem_re = 1'b1;
          raddr  = cur_idx + 1'b1;
        end
      end
      S_HOLD: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      key_r <= key;
    end
    if (state == S_ISSUE) begin
      cur_idx <= start;
      cnt     <= '0;
    end else if (state == S_PROBE && !done) begin
      cur_idx <= cur_idx + 1'b1;
      cnt     <= cnt + 1'b1;
    end
    if (done) begin
      hold_status <= probe_status;
      hold_idx    <= cur_idx;
    end
  end

  a_write_only_clear_or_probe: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_PROBE))
    else $error("key memory written outside clear or probe");

  a_full_after_all_slots: assert property (@(posedge clk) disable iff (rst)
    (res.valid && state == S_PROBE && res.status == ST_FULL) |-> last_probe)
    else $error("table full reported before every slot was probed");

  a_issue_then_probe: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE) |=> (state == S_PROBE && cur_idx == $past(start)))
    else $error("probe did not start at the hashed slot");

  a_hold_is_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD && $past(state == S_HOLD)) |-> $stable(res))
    else $error("held result changed while waiting");

endmodule

### rtl/core/linear_probe_hash_set_insert_core.sv
// Linear probing hash set insert core: hash unit, probe engine and the
// output register. Depends on lphs_pkg, lphs_hash and lphs_probe.
//
// Each key is inserted into a 32768-slot open-addressing set; the result
// word gives status (0 inserted, 1 already present or key zero, 2 full) and
// the slot where the search ended. After reset the core runs a clearing pass
// over the key memory with in_stall high. An insert probes from its hashed
// start slot onward, from 1 slot on a lightly loaded table up to 32768 when
// full, and takes no new key until its word leaves the probe engine; the
// single read port of the key memory gives one probe per cycle. The output
// register lets the next key enter while the previous word waits.
module linear_probe_hash_set_insert_core import lphs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [KEY_W-1:0]        key,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STATUS_W-1:0]     status,
  output logic [SLOT_FIELD_W-1:0] slot
);

  logic              in_ready;
  logic [SLOT_W-1:0] start;
  res_t              res;
  logic              res_ready;

  lphs_hash u_hash (
    .clk   (clk),
    .en    (in_valid && in_ready),
    .key   (key),
    .start (start)
  );

  lphs_probe u_probe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .key       (key),
    .start     (start),
    .res       (res),
    .res_ready (res_ready)
  );

  assign in_stall  = !in_ready;
  assign res_ready = !out_valid || !out_stall;

  // load a new word when the register is empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      status <= res.status;
      slot   <= res.slot;
    end
  end

endmodule
